FILE: hdl/utb_pkg.sv
// ----------------------------------------------------------------------------
// utb_pkg
// Shared types and constants for the UTF-8 text bounds core: item layouts,
// configuration register indexes, glyph memory entry, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package utb_pkg;

    localparam int GLYPH_SLOTS = 256;
    localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int CNT_W       = $clog2(GLYPH_SLOTS + 1);
    localparam int MAX_SCALE   = 8;

    localparam int SCALE_W  = 4;
    localparam int COUNT_W  = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_SCALE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FONT_PRESENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEXT = 1'b1;

    localparam logic [15:0] FALLBACK_CODE = 16'h003F;
    localparam logic [15:0] WIDTH_LIMIT   = 16'hFFFF;
    localparam logic [11:0] HEIGHT_LIMIT  = 12'hFFF;

    typedef struct packed {
        logic               action;
        logic [7:0]         entry_index;
        logic [15:0]        glyph_code;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [7:0]  glyph_y_offset;
        logic [7:0]         text_byte;
        logic               last_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        text_width;
        logic [11:0]        text_height;
        logic signed [7:0]  lowest_offset;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        code;
        logic [7:0]         width;
        logic [7:0]         height;
        logic signed [7:0]  offset;
    } glyph_entry_t;

    typedef struct packed {
        logic write_entry;
        logic take_byte;
        logic search_en;
        logic add_char;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_last;
        logic char_done;
        logic need_search;
        logic search_done;
        logic last_pending;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hdl/utf8_text_bounds_core.sv
// ----------------------------------------------------------------------------
// utf8_text_bounds_core
// Measures a UTF-8 string against a loaded glyph metrics table and returns
// the scaled width, height and lowest y offset at the final byte.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_item_t  (load or text byte)
//   out      output     out_valid / out_stall  out_item_t (one per string)
//   cfg      input      cfg_wr_en              cfg_index, cfg_data
//
// A load item or a byte that completes no character is taken in idle alone.
// A byte that completes a character adds the glyph scan, up to glyph_count
// entries (capped at 256, one glyph memory entry read per cycle), then the
// accumulate step. The final byte adds the result step.
// Reset leaves the glyph memory unwritten; no clearing pass is run.
// A finished result waits in the output register while new items are taken;
// only the result step itself waits for out_stall to drop.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_text_bounds_core
    import utb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    utb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    utb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    a_search_then_add: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.search_en && status.search_done) |=> cmd.add_char)
        else $error("scan end not followed by accumulate");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result raised without result step");

    a_load_no_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (in_data.action == ACT_LOAD)) |=> !cmd.search_en)
        else $error("load item started a scan");
`endif

endmodule

`default_nettype wire

FILE: hdl/utb_ctrl.sv
// ----------------------------------------------------------------------------
// utb_ctrl
// Sequencer for the text bounds core: takes one item at a time, runs the
// glyph scan, the accumulate step and the result step.
// ----------------------------------------------------------------------------
`default_nettype none

module utb_ctrl
    import utb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_ADD    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (status.is_load)
                    begin
                        cmd.write_entry = 1'b1;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                        if (status.char_done)
                        begin
                            state_next = status.need_search ? ST_SEARCH : ST_ADD;
                        end
                        else if (status.is_last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_en = 1'b1;
                if (status.search_done)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.add_char = 1'b1;
                state_next   = status.last_pending ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/utb_datapath.sv
// ----------------------------------------------------------------------------
// utb_datapath
// Glyph memory, UTF-8 decoder, scan unit, metric accumulators, result
// arithmetic and output register of the text bounds core.
// ----------------------------------------------------------------------------
`default_nettype none

module utb_datapath
    import utb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    output dp_status_t                 status,
    input  wire in_item_t              in_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output out_item_t                  out_data
);

    glyph_entry_t mem [GLYPH_SLOTS];

    logic [SCALE_W-1:0] scale_reg;
    logic               font_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [1:0]         pending_reg,  pending_next;
    logic [15:0]        partial_reg,  partial_next;
    logic [15:0]        cp_reg;
    logic               last_reg;

    logic [CNT_W-1:0]   scan_reg,     scan_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    glyph_entry_t       rd_data_reg;
    logic               fb_found_reg, fb_found_next;
    glyph_entry_t       fb_reg,       fb_next;
    glyph_entry_t       sel_reg,      sel_next;

    logic [15:0]        wsum_reg,     wsum_next;
    logic [7:0]         tall_reg,     tall_next;
    logic signed [7:0]  min_off_reg,  min_off_next;
    logic signed [7:0]  max_off_reg,  max_off_next;

    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg,  out_data_next;

    logic [SCALE_W-1:0] scale;
    logic [CNT_W-1:0]   slots;
    logic [15:0]        dec_cp;
    logic               dec_done;
    logic               hit;
    logic               at_end;
    logic [8:0]         adv;
    logic [12:0]        prod;
    logic [16:0]        wsum_add;
    logic signed [8:0]  off_diff;
    logic [9:0]         span;
    logic [13:0]        th_full;
    logic [15:0]        tw;
    logic [15:0]        wr_slot;

    // ---- configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_W'(1);
            font_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TEXT_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_FONT_PRESENT: font_reg  <= cfg_data[0];
                CFG_GLYPH_COUNT:  count_reg <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (scale_reg == '0)
        begin
            scale = SCALE_W'(1);
        end
        else if (32'(scale_reg) > MAX_SCALE)
        begin
            scale = SCALE_W'(MAX_SCALE);
        end
        else
        begin
            scale = scale_reg;
        end
        slots = (16'(count_reg) > 16'(GLYPH_SLOTS)) ? CNT_W'(GLYPH_SLOTS) : CNT_W'(count_reg);
    end

    // ---- glyph memory
    assign wr_slot = 16'(in_data.entry_index);

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry && (wr_slot < 16'(GLYPH_SLOTS)))
        begin
            mem[wr_slot[SLOT_W-1:0]] <= '{code:   in_data.glyph_code,
                                          width:  in_data.glyph_width,
                                          height: in_data.glyph_height,
                                          offset: in_data.glyph_y_offset};
        end
        rd_data_reg <= mem[scan_reg[SLOT_W-1:0]];
        rd_idx_reg  <= scan_reg;
    end

    // ---- UTF-8 decode
    always_comb
    begin
        dec_cp       = 16'(in_data.text_byte);
        dec_done     = 1'b0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (pending_reg != 2'd0)
        begin
            dec_cp       = {partial_reg[9:0], in_data.text_byte[5:0]};
            partial_next = dec_cp;
            pending_next = pending_reg - 2'd1;
            dec_done     = (pending_reg == 2'd1);
        end
        else if (!in_data.text_byte[7])
        begin
            dec_done = 1'b1;
        end
        else if (in_data.text_byte[7:5] == 3'b110)
        begin
            partial_next = {11'd0, in_data.text_byte[4:0]};
            pending_next = 2'd1;
        end
        else if (in_data.text_byte[7:4] == 4'b1110)
        begin
            partial_next = {12'd0, in_data.text_byte[3:0]};
            pending_next = 2'd2;
        end
    end

    // ---- scan
    assign hit    = rd_valid_reg && (rd_data_reg.code == cp_reg);
    assign at_end = rd_valid_reg && (rd_idx_reg == slots - CNT_W'(1));

    always_comb
    begin
        scan_next     = scan_reg;
        rd_valid_next = 1'b0;
        fb_found_next = fb_found_reg;
        fb_next       = fb_reg;
        sel_next      = sel_reg;
        if (cmd.take_byte)
        begin
            scan_next     = '0;
            fb_found_next = 1'b0;
            sel_next      = '0;
        end
        else if (cmd.search_en)
        begin
            if (scan_reg < slots)
            begin
                rd_valid_next = 1'b1;
                scan_next     = scan_reg + CNT_W'(1);
            end
            if (rd_valid_reg && !fb_found_reg && (rd_data_reg.code == FALLBACK_CODE))
            begin
                fb_found_next = 1'b1;
                fb_next       = rd_data_reg;
            end
            if (hit)
            begin
                sel_next = rd_data_reg;
            end
            else if (at_end)
            begin
                if (fb_found_reg)
                begin
                    sel_next = fb_reg;
                end
                else if (rd_data_reg.code == FALLBACK_CODE)
                begin
                    sel_next = rd_data_reg;
                end
            end
        end
    end

    // ---- accumulate and result
    assign adv      = {1'b0, sel_reg.width} + 9'd1;
    assign prod     = 13'(adv) * 13'(scale);
    assign wsum_add = 17'(wsum_reg) + 17'(prod);
    assign off_diff = {max_off_reg[7], max_off_reg} - {min_off_reg[7], min_off_reg};
    assign span     = 10'(tall_reg) + 10'($unsigned(off_diff));
    assign th_full  = 14'(span) * 14'(scale);

    always_comb
    begin
        if (wsum_reg == WIDTH_LIMIT)
        begin
            tw = WIDTH_LIMIT;
        end
        else if (wsum_reg >= 16'(scale))
        begin
            tw = wsum_reg - 16'(scale);
        end
        else
        begin
            tw = '0;
        end
    end

    always_comb
    begin
        wsum_next      = wsum_reg;
        tall_next      = tall_reg;
        min_off_next   = min_off_reg;
        max_off_next   = max_off_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (cmd.add_char)
        begin
            wsum_next = (wsum_add > 17'(WIDTH_LIMIT)) ? WIDTH_LIMIT : wsum_add[15:0];
            if (sel_reg.height > tall_reg)
            begin
                tall_next = sel_reg.height;
            end
            if (sel_reg.offset < min_off_reg)
            begin
                min_off_next = sel_reg.offset;
            end
            if (sel_reg.offset > max_off_reg)
            begin
                max_off_next = sel_reg.offset;
            end
        end
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            if (font_reg)
            begin
                out_data_next.text_width    = tw;
                out_data_next.text_height   = (th_full > 14'(HEIGHT_LIMIT)) ?
                                              HEIGHT_LIMIT : th_full[11:0];
                out_data_next.lowest_offset = min_off_reg;
            end
            else
            begin
                out_data_next = '0;
            end
            wsum_next    = '0;
            tall_next    = '0;
            min_off_next = '0;
            max_off_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            partial_reg   <= '0;
            last_reg      <= 1'b0;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            fb_found_reg  <= 1'b0;
            wsum_reg      <= '0;
            tall_reg      <= '0;
            min_off_reg   <= '0;
            max_off_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
                last_reg    <= in_data.last_byte;
            end
            else if (cmd.finish)
            begin
                pending_reg <= '0;
                partial_reg <= '0;
                last_reg    <= 1'b0;
            end
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            fb_found_reg  <= fb_found_next;
            wsum_reg      <= wsum_next;
            tall_reg      <= tall_next;
            min_off_reg   <= min_off_next;
            max_off_reg   <= max_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            cp_reg <= dec_cp;
        end
        fb_reg       <= fb_next;
        sel_reg      <= sel_next;
        out_data_reg <= out_data_next;
    end

    // ---- status and outputs
    always_comb
    begin
        status.is_load      = (in_data.action == ACT_LOAD);
        status.is_last      = in_data.last_byte;
        status.char_done    = dec_done;
        status.need_search  = font_reg && (slots != '0);
        status.search_done  = hit || at_end;
        status.last_pending = last_reg;
        status.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for utf8_text_bounds_core. It fills the glyph table, then feeds
// well-formed and broken UTF-8 strings under a range of scale, font and glyph
// count settings. Sender gaps and receiver stalls vary by phase. A scoreboard
// predicts the width, height and lowest offset of every string and checks
// each result in order.
// ----------------------------------------------------------------------------

module tb;
    import utb_pkg::*;

    localparam int CLOCK_HALF    = 10;
    localparam int SETTLE_CYCLES = GLYPH_SLOTS + 44;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 55;

    class bounds_tracker;
        logic [SCALE_W-1:0] scale_reg;
        logic               font_on;
        logic [COUNT_W-1:0] count_reg;
        logic [15:0]        code_mem [GLYPH_SLOTS];
        logic [7:0]         width_mem [GLYPH_SLOTS];
        logic [7:0]         height_mem [GLYPH_SLOTS];
        logic signed [7:0]  offset_mem [GLYPH_SLOTS];
        int                 pending;
        logic [15:0]        partial;
        int                 width_sum;
        int                 tallest;
        int                 low_off;
        int                 high_off;
        out_item_t          bounds_due [$];
        int                 checked;
        int                 faults;

        function new();
            scale_reg = 4'd1;
            font_on   = 1'b0;
            count_reg = 9'd0;
            checked   = 0;
            faults    = 0;
            clear_string();
        endfunction

        function void clear_string();
            pending   = 0;
            partial   = 16'h0000;
            width_sum = 0;
            tallest   = 0;
            low_off   = 0;
            high_off  = 0;
        endfunction

        function int eff_scale();
            if (scale_reg == 4'd0)
                return 1;
            if (int'(scale_reg) > MAX_SCALE)
                return MAX_SCALE;
            return int'(scale_reg);
        endfunction

        function int search_span();
            return (int'(count_reg) > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(count_reg);
        endfunction

        function int find_slot(logic [15:0] cp, int span);
            for (int i = 0; i < span; i++)
                if (code_mem[i] == cp)
                    return i;
            return span;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_TEXT_SCALE:   scale_reg = value[SCALE_W-1:0];
                CFG_FONT_PRESENT: font_on   = value[0];
                CFG_GLYPH_COUNT:  count_reg = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void add_glyph(logic [15:0] cp);
            int span;
            int hit;
            int w;
            int h;
            int off;
            w   = 0;
            h   = 0;
            off = 0;
            if (font_on) begin
                span = search_span();
                hit  = find_slot(cp, span);
                if (hit == span)
                    hit = find_slot(FALLBACK_CODE, span);
                if (hit < span) begin
                    w   = int'(width_mem[hit]);
                    h   = int'(height_mem[hit]);
                    off = int'(offset_mem[hit]);
                end
            end
            width_sum += (w + 1) * eff_scale();
            if (width_sum > int'(WIDTH_LIMIT))
                width_sum = int'(WIDTH_LIMIT);
            if (h > tallest)
                tallest = h;
            if (off < low_off)
                low_off = off;
            if (off > high_off)
                high_off = off;
        endfunction

        function void take_byte(logic [7:0] b);
            if (pending > 0) begin
                partial = {partial[9:0], b[5:0]};
                pending--;
                if (pending == 0)
                    add_glyph(partial);
            end
            else if (b[7] == 1'b0)
                add_glyph({8'h00, b});
            else if (b[7:5] == 3'b110) begin
                partial = {11'd0, b[4:0]};
                pending = 1;
            end
            else if (b[7:4] == 4'b1110) begin
                partial = {12'd0, b[3:0]};
                pending = 2;
            end
        endfunction

        function void take_item(in_item_t item);
            out_item_t res;
            int        s;
            int        span_h;
            if (item.action == ACT_LOAD) begin
                code_mem[item.entry_index]   = item.glyph_code;
                width_mem[item.entry_index]  = item.glyph_width;
                height_mem[item.entry_index] = item.glyph_height;
                offset_mem[item.entry_index] = item.glyph_y_offset;
                return;
            end
            take_byte(item.text_byte);
            if (!item.last_byte)
                return;
            s   = eff_scale();
            res = '0;
            if (font_on) begin
                if (width_sum >= int'(WIDTH_LIMIT))
                    res.text_width = WIDTH_LIMIT;
                else if (width_sum >= s)
                    res.text_width = 16'(width_sum - s);
                span_h = (tallest + high_off - low_off) * s;
                res.text_height = (span_h > int'(HEIGHT_LIMIT)) ? HEIGHT_LIMIT : 12'(span_h);
                res.lowest_offset = 8'(low_off);
            end
            bounds_due.push_back(res);
            clear_string();
        endfunction

        function void check_bounds(out_item_t got);
            out_item_t want;
            if (bounds_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("result with no string pending: width %0d height %0d lowest %0d",
                             got.text_width, got.text_height, got.lowest_offset);
                return;
            end
            want = bounds_due.pop_front();
            checked++;
            if (got.text_width !== want.text_width || got.text_height !== want.text_height ||
                got.lowest_offset !== want.lowest_offset) begin
                faults++;
                if (faults <= 10)
                    $display("mismatch at %0t: width %0d/%0d height %0d/%0d lowest %0d/%0d (exp/act)",
                             $realtime, want.text_width, got.text_width, want.text_height,
                             got.text_height, want.lowest_offset, got.lowest_offset);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TEXT_SCALE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            cycle_count = 0;
    int            loads_sent = 0;
    int            bytes_sent = 0;
    logic [15:0]   alphabet [32];
    logic [7:0]    str_bytes [$];
    bounds_tracker sb;

    utf8_text_bounds_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLOCK_HALF) clk = 1'b1;
        #(CLOCK_HALF) clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_bounds(out_data);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic in_item_t text_item(logic [7:0] b, logic last);
        logic [63:0] noise;
        in_item_t    item;
        noise = {$urandom, $urandom};
        item = noise[$bits(in_item_t)-1:0];
        item.action    = ACT_TEXT;
        item.text_byte = b;
        item.last_byte = last;
        return item;
    endfunction

    function automatic in_item_t load_item(int slot, logic [15:0] code, int w, int h, int off);
        logic [63:0] noise;
        in_item_t    item;
        noise = {$urandom, $urandom};
        item = noise[$bits(in_item_t)-1:0];
        item.action         = ACT_LOAD;
        item.entry_index    = 8'(slot);
        item.glyph_code     = code;
        item.glyph_width    = 8'(w);
        item.glyph_height   = 8'(h);
        item.glyph_y_offset = 8'(off);
        return item;
    endfunction

    function automatic in_item_t random_glyph(int slot);
        logic [15:0] code;
        int          pick;
        int          w;
        pick = int'($urandom_range(9));
        if (pick < 7)
            code = alphabet[$urandom_range(31)];
        else if (pick < 9)
            code = 16'($urandom);
        else
            code = FALLBACK_CODE;
        pick = int'($urandom_range(3));
        if (pick == 0)
            w = 255;
        else if (pick == 1)
            w = int'($urandom_range(7));
        else
            w = int'($urandom_range(255));
        return load_item(slot, code, w, int'($urandom_range(255)),
                         int'($urandom_range(255)) - 128);
    endfunction

    function automatic logic [15:0] pick_code();
        int span;
        int pick;
        span = sb.search_span();
        pick = int'($urandom_range(19));
        if (pick < 12 && span > 0)
            return sb.code_mem[$urandom_range(span - 1)];
        if (pick < 15)
            return alphabet[$urandom_range(31)];
        if (pick < 18)
            return 16'($urandom);
        return FALLBACK_CODE;
    endfunction

    function automatic void push_code(logic [15:0] cp);
        int         form;
        logic [1:0] top;
        form = (cp < 16'h0080) ? 1 : (cp < 16'h0800) ? 2 : 3;
        if (form < 3 && $urandom_range(9) == 0)
            form++;
        top = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'b10;
        case (form)
            1: str_bytes.push_back(cp[7:0]);
            2:
            begin
                str_bytes.push_back({3'b110, cp[10:6]});
                str_bytes.push_back({top, cp[5:0]});
            end
            default:
            begin
                str_bytes.push_back({4'b1110, cp[15:12]});
                str_bytes.push_back({top, cp[11:6]});
                str_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    task automatic send_item(in_item_t item);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.take_item(item);
        if (item.action == ACT_LOAD)
            loads_sent++;
        else
            bytes_sent++;
    endtask

    task automatic send_string(logic with_end);
        for (int i = 0; i < str_bytes.size(); i++)
            send_item(text_item(str_bytes[i], with_end && (i == str_bytes.size() - 1)));
    endtask

    task automatic build_clean(int chars);
        str_bytes.delete();
        repeat (chars) push_code(pick_code());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        sb.note_config(idx, cfg_data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic settle(int extra);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.bounds_due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    initial
    begin
        int          phase_start;
        int          pick;
        int          scale_val;
        int          font_val;
        int          count_val;
        int          span;
        logic        drained;
        logic [15:0] code;

        sb = new();
        alphabet[0] = 16'h0000;
        alphabet[1] = 16'h0041;
        alphabet[2] = 16'h007F;
        alphabet[3] = 16'h00E9;
        alphabet[4] = 16'h07FF;
        alphabet[5] = 16'h0800;
        alphabet[6] = 16'h8000;
        alphabet[7] = 16'hFFFF;
        for (int i = 8; i < 32; i++) begin
            pick = int'($urandom_range(2));
            if (pick == 0)
                alphabet[i] = 16'($urandom_range(16'h007F));
            else if (pick == 1)
                alphabet[i] = 16'($urandom_range(16'h07FF, 16'h0080));
            else
                alphabet[i] = 16'($urandom_range(16'hFFFF, 16'h0800));
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no font loaded yet: all-zero result
        send_item(text_item(8'h41, 1'b1));
        send_item(load_item(0, FALLBACK_CODE, 5, 7, -3));
        send_item(load_item(1, 16'h0041, 255, 255, 127));
        send_item(load_item(2, 16'h00E9, 0, 0, -128));
        send_item(load_item(3, 16'hFFFF, 10, 1, 0));
        send_item(load_item(4, 16'h0000, 3, 2, 1));
        settle(SETTLE_CYCLES);
        write_reg(CFG_FONT_PRESENT, 1);
        write_reg(CFG_GLYPH_COUNT, 5);
        write_reg(CFG_TEXT_SCALE, 0);
        str_bytes = '{8'h41};
        send_string(1'b1);
        str_bytes = '{8'hC3, 8'hA9, 8'hEF, 8'hBF, 8'hBF, 8'h00};
        send_string(1'b1);
        str_bytes = '{8'h5A};
        send_string(1'b1);
        str_bytes = '{8'h80, 8'hF5, 8'h41};
        send_string(1'b1);
        str_bytes = '{8'h41, 8'hE2, 8'h82};
        send_string(1'b1);
        str_bytes = '{8'hC1, 8'h41};
        send_string(1'b1);
        str_bytes = '{8'hFF};
        send_string(1'b1);

        // fill every slot so that any glyph count is safe to search
        send_idle_pct = 15;
        stall_pct     = 15;
        for (int slot = 0; slot < GLYPH_SLOTS; slot++)
            send_item(random_glyph(slot));

        for (int phase = 0; phase < PHASES; phase++) begin
            settle(SETTLE_CYCLES);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 87;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            case (phase)
                0: scale_val = 8;
                1: scale_val = 1;
                2: scale_val = 15;
                3: scale_val = 0;
                default: scale_val = int'($urandom_range(15));
            endcase
            font_val = (phase == 4 || $urandom_range(9) == 0) ? 0 : 1;
            pick = int'($urandom_range(9));
            case (phase)
                5: count_val = 256;
                6: count_val = 511;
                7: count_val = 0;
                8: count_val = 257;
                default:
                begin
                    if (pick < 7)
                        count_val = int'($urandom_range(16, 1));
                    else if (pick < 9)
                        count_val = int'($urandom_range(64, 17));
                    else
                        count_val = int'($urandom_range(300, 65));
                end
            endcase
            write_reg(CFG_TEXT_SCALE, scale_val);
            write_reg(CFG_FONT_PRESENT, font_val);
            write_reg(CFG_GLYPH_COUNT, count_val);

            phase_start = loads_sent + bytes_sent;
            drained = 1'b0;
            if (scale_val >= MAX_SCALE) begin
                // long run of a wide glyph to push the width into saturation
                span = sb.search_span();
                code = pick_code();
                for (int k = 0; k < span; k++)
                    if (sb.width_mem[k] >= 8'd200) begin
                        code = sb.code_mem[k];
                        break;
                    end
                str_bytes.delete();
                repeat ($urandom_range(40, 24)) push_code(code);
                send_string(1'b1);
            end

            while (loads_sent + bytes_sent - phase_start < PHASE_ITEMS) begin
                if (phase % 3 == 1 && !drained &&
                    loads_sent + bytes_sent - phase_start > PHASE_ITEMS / 2) begin
                    settle(0);
                    drained = 1'b1;
                end
                pick = int'($urandom_range(19));
                if (pick < 2) begin
                    repeat ($urandom_range(4, 1)) send_item(random_glyph(int'($urandom_range(255))));
                end
                else if (pick < 5) begin
                    str_bytes.delete();
                    repeat ($urandom_range(6, 1)) begin
                        case ($urandom_range(4))
                            0: push_code(pick_code());
                            1: str_bytes.push_back(8'($urandom_range(255)));
                            2: str_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
                            3: str_bytes.push_back(8'($urandom_range(8'hFF, 8'hF0)));
                            default: str_bytes.push_back(8'($urandom_range(8'hEF, 8'hC0)));
                        endcase
                    end
                    send_string(1'b1);
                end
                else begin
                    build_clean(int'($urandom_range(8, 1)));
                    send_string(1'b1);
                end
            end

            // leave a string open across the settings change
            if ($urandom_range(1) == 1) begin
                build_clean(int'($urandom_range(2, 1)));
                while (str_bytes.size() > 1 && $urandom_range(1) == 1)
                    void'(str_bytes.pop_back());
                send_string(1'b0);
            end
        end

        str_bytes = '{8'h41};
        send_string(1'b1);
        settle(SETTLE_CYCLES);
        $display("covered %0d glyph loads and %0d text bytes over %0d setting phases",
                 loads_sent, bytes_sent, PHASES);
        $display("%0d string results compared, %0d mismatches, %0d left pending",
                 sb.checked, sb.faults, sb.bounds_due.size());
        if (sb.faults == 0 && sb.bounds_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
